// ===== rtl/micepd_pkg.sv =====
// ----------------------------------------------------------------------------
// micepd_pkg
// Types, character codes and helper functions shared by the Mic-E decoder.
// ----------------------------------------------------------------------------
package micepd_pkg;

	localparam logic [7:0] TYPE_CUR    = 8'h60;
	localparam logic [7:0] TYPE_OLD    = 8'h27;
	localparam logic [7:0] TYPE_BETA_A = 8'h1c;
	localparam logic [7:0] TYPE_BETA_B = 8'h1d;

	localparam logic [7:0] CHAR_BIAS   = 8'd28;
	localparam logic [7:0] INFO_MIN    = 8'h1c;
	localparam logic [7:0] INFO_MAX    = 8'h7f;
	localparam logic [7:0] SYM_MIN     = 8'h20;
	localparam logic [7:0] SYM_MAX     = 8'h7e;
	localparam logic [7:0] CH_SLASH    = 8'h2f;
	localparam logic [7:0] CH_BSLASH   = 8'h5c;
	localparam logic [7:0] CH_STAR     = 8'h2a;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_RBRACKET = 8'h5d;
	localparam logic [7:0] CH_GT       = 8'h3e;

	localparam logic [3:0] DEST_LEN    = 4'd6;
	localparam logic [3:0] DIGIT_BLANK = 4'd15;

	localparam logic [10:0] COURSE_MAX = 11'd360;
	localparam logic [10:0] SPEED_MAX  = 11'd999;
	localparam logic [10:0] SPEED_WRAP = 11'd800;
	localparam logic [10:0] COURSE_WRAP = 11'd400;

	typedef struct packed {
		logic [47:0] dest_chars;
		logic [3:0]  dest_length;
		logic [63:0] info_head;
		logic [7:0]  info_byte_eight;
		logic [7:0]  info_byte_nine;
		logic [8:0]  info_length;
	} mic_in_t;

	typedef struct packed {
		logic        accepted;
		logic [23:0] lat_digits;
		logic [1:0]  hemispheres;
		logic [7:0]  lon_degrees;
		logic [6:0]  lon_minutes;
		logic [6:0]  lon_hundredths;
		logic [9:0]  speed;
		logic [8:0]  course;
		logic [7:0]  symbol_code;
		logic [7:0]  symbol_table;
		logic [3:0]  message_code;
		logic        messaging_capable;
	} mic_out_t;

	typedef struct packed {
		logic        ok;
		logic        rev1;
		logic        lon_hundred;
		logic [6:0]  lon_dd;
		logic [6:0]  lon_mm;
		logic [6:0]  lon_hh;
		logic [6:0]  sp;
		logic [6:0]  dc;
		logic [6:0]  se;
		logic [23:0] lat_digits;
		logic [1:0]  hemispheres;
		logic [3:0]  message_code;
		logic [7:0]  symbol_code;
		logic [7:0]  symbol_table;
		logic        messaging_capable;
	} micepd_s1_t;

	function automatic logic [3:0] lat_digit(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'h00;
			if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30;
			end else if (c >= 8'h41 && c <= 8'h4a) begin
				t = c - 8'h41;
			end else if (c >= 8'h50 && c <= 8'h59) begin
				t = c - 8'h50;
			end else begin
				t = {4'd0, DIGIT_BLANK};
			end
			return t[3:0];
		end
	endfunction

	function automatic logic table_ok(input logic [7:0] s);
		begin
			return (s == CH_SLASH) || (s == CH_BSLASH) || (s == CH_STAR) ||
				(s == CH_BANG) || (s >= 8'h30 && s <= 8'h39) ||
				(s >= 8'h61 && s <= 8'h6a) || (s >= 8'h41 && s <= 8'h5a);
		end
	endfunction

endpackage

// ===== rtl/mic_e_position_decoder.sv =====
// ----------------------------------------------------------------------------
// mic_e_position_decoder
// Decodes one Mic-E packet header per word into position, speed, course,
// symbol and message fields, or rejects it with an all-zero result.
//
//   Channel   Handshake          Payload
//   command   start / busy       cmd    (mic_in_t)
//   result    done (strobe)      result (mic_out_t)
//
// A word is taken every cycle; its result passes through the three register
// stages (check, arithmetic, output) before it is on the ports. busy stays
// low because the pipeline never holds.
// Reset clears the valid bits of every stage; no result follows reset.
// ----------------------------------------------------------------------------
module mic_e_position_decoder
	import micepd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  mic_in_t  cmd,
	output logic     done,
	output mic_out_t result
);

	logic       vld_s1;
	micepd_s1_t hdr_s1;
	logic       vld_s2;
	mic_out_t   res;
	logic       done_s3;
	mic_out_t   result_s3;

	micepd_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.vld_s1 (vld_s1),
		.hdr_s1 (hdr_s1)
	);

	micepd_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.hdr_s1 (hdr_s1),
		.vld_s2 (vld_s2),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			result_s3 <= res;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_s3;
	assign result = result_s3;

endmodule

// ===== rtl/micepd_check.sv =====
// ----------------------------------------------------------------------------
// micepd_check
// First stage: validates the header and splits it into raw fields.
// ----------------------------------------------------------------------------
module micepd_check
	import micepd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  mic_in_t    cmd,
	output logic       vld_s1,
	output micepd_s1_t hdr_s1
);

	logic [7:0]  d [6];
	logic [7:0]  b [8];
	logic        bad;
	logic        rev1;
	logic        type_bad;
	logic [3:0]  lat [6];
	logic [2:0]  std_msg;
	logic [3:0]  cus_msg;
	logic        lat_bad;
	logic [7:0]  tbl;
	micepd_s1_t  hdr;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			d[i]   = cmd.dest_chars[8*(5-i) +: 8];
			lat[i] = lat_digit(d[i]);
		end
		for (int k = 0; k < 8; k++) begin
			b[k] = cmd.info_head[8*(7-k) +: 8];
		end
	end

	always_comb begin
		bad = (cmd.info_length > 9'd255) || (cmd.dest_length != DEST_LEN);
		for (int i = 0; i < 6; i++) begin
			if (d[i] < 8'h30 || d[i] > 8'h5a || d[i] == 8'h4d || d[i] == 8'h4e ||
				d[i] == 8'h4f) begin
				bad = 1'b1;
			end
			if (d[i] > 8'h39 && d[i] < 8'h41) begin
				bad = 1'b1;
			end
			if (i >= 3 && d[i] >= 8'h41 && d[i] <= 8'h4b) begin
				bad = 1'b1;
			end
		end
		for (int k = 1; k < 7; k++) begin
			if (b[k] < INFO_MIN || b[k] > INFO_MAX) begin
				bad = 1'b1;
			end
		end
	end

	always_comb begin
		rev1     = 1'b0;
		type_bad = 1'b0;
		case (b[0]) inside
			TYPE_CUR, TYPE_OLD: begin
				rev1     = 1'b1;
				type_bad = cmd.info_length < 9'd9;
			end
			TYPE_BETA_A, TYPE_BETA_B: begin
				type_bad = cmd.info_length < 9'd8;
			end
			default: begin
				type_bad = 1'b1;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			std_msg[2-i] = d[i] >= 8'h50;
		end
		cus_msg = ((d[0] >= 8'h41 && d[0] < 8'h4c) ? 4'hc : 4'h0) |
			((d[1] >= 8'h41 && d[1] < 8'h4c) ? 4'ha : 4'h0) |
			((d[2] >= 8'h41 && d[2] < 8'h4c) ? 4'h9 : 4'h0);
		lat_bad = 1'b0;
		if (lat[0] == 4'd9 && (lat[1] != 4'd0 || lat[2] != 4'd0 || lat[3] != 4'd0 ||
			lat[4] != 4'd0 || lat[5] != 4'd0)) begin
			lat_bad = 1'b1;
		end
		if ((lat[2] != DIGIT_BLANK && lat[2] > 4'd5) ||
			(lat[4] != DIGIT_BLANK && lat[4] > 4'd5)) begin
			lat_bad = 1'b1;
		end
		if (lat[0] == DIGIT_BLANK || lat[1] == DIGIT_BLANK) begin
			lat_bad = 1'b1;
		end
		tbl = rev1 ? cmd.info_byte_eight : CH_SLASH;

		hdr.ok = !bad && !type_bad && !lat_bad && b[7] >= SYM_MIN && b[7] <= SYM_MAX &&
			table_ok(tbl);
		hdr.rev1              = rev1;
		hdr.lon_hundred       = d[4] >= 8'h50;
		hdr.lon_dd            = 7'(b[1] - CHAR_BIAS);
		hdr.lon_mm            = 7'(b[2] - CHAR_BIAS);
		hdr.lon_hh            = 7'(b[3] - CHAR_BIAS);
		hdr.sp                = 7'(b[4] - CHAR_BIAS);
		hdr.dc                = 7'(b[5] - CHAR_BIAS);
		hdr.se                = 7'(b[6] - CHAR_BIAS);
		hdr.lat_digits        = {lat[0], lat[1], lat[2], lat[3], lat[4], lat[5]};
		hdr.hemispheres       = {d[5] >= 8'h50, d[3] >= 8'h50};
		hdr.message_code      = (std_msg != 3'd0) ? {1'b0, std_msg} : cus_msg;
		hdr.symbol_code       = b[7];
		hdr.symbol_table      = tbl;
		hdr.messaging_capable = (cmd.info_length >= 9'd10) &&
			(cmd.info_byte_nine == CH_RBRACKET || cmd.info_byte_nine == CH_GT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hdr_s1 <= hdr;
		end
	end

endmodule

// ===== rtl/micepd_arith.sv =====
// ----------------------------------------------------------------------------
// micepd_arith
// Second stage and final logic: longitude, speed and course offsets and the
// range checks that follow them.
// ----------------------------------------------------------------------------
module micepd_arith
	import micepd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_s1,
	input  micepd_s1_t hdr_s1,
	output logic       vld_s2,
	output mic_out_t   res
);

	typedef struct packed {
		logic        ok;
		logic        rev1;
		logic [7:0]  lon_dd;
		logic [6:0]  lon_mm;
		logic [6:0]  lon_hh;
		logic [10:0] sp10;
		logic [3:0]  q;
		logic [3:0]  r;
		logic [6:0]  se;
		logic [23:0] lat_digits;
		logic [1:0]  hemispheres;
		logic [3:0]  message_code;
		logic [7:0]  symbol_code;
		logic [7:0]  symbol_table;
		logic        messaging_capable;
	} arith_s2_t;

	arith_s2_t   nxt;
	arith_s2_t   st_s2;
	logic [7:0]  dd;
	logic [14:0] prod;
	logic [6:0]  q10;
	logic [10:0] spd;
	logic [10:0] cse;
	logic [10:0] r100;

	always_comb begin
		dd = {1'b0, hdr_s1.lon_dd} + ((hdr_s1.rev1 && hdr_s1.lon_hundred) ? 8'd100 : 8'd0);
		if (hdr_s1.rev1 && dd >= 8'd180 && dd <= 8'd189) begin
			dd = dd - 8'd80;
		end else if (hdr_s1.rev1 && dd >= 8'd190 && dd <= 8'd199) begin
			dd = dd - 8'd190;
		end
		prod = 15'(hdr_s1.dc) * 15'd205;
		q10  = {prod[14:11], 3'b000} + {2'b00, prod[14:11], 1'b0};

		nxt.ok                = hdr_s1.ok;
		nxt.rev1              = hdr_s1.rev1;
		nxt.lon_dd            = dd;
		nxt.lon_mm            = (hdr_s1.rev1 && hdr_s1.lon_mm >= 7'd60) ?
			hdr_s1.lon_mm - 7'd60 : hdr_s1.lon_mm;
		nxt.lon_hh            = hdr_s1.lon_hh;
		nxt.sp10              = {1'b0, hdr_s1.sp, 3'b000} + {3'b000, hdr_s1.sp, 1'b0};
		nxt.q                 = prod[14:11];
		nxt.r                 = 4'(hdr_s1.dc - q10);
		nxt.se                = hdr_s1.se;
		nxt.lat_digits        = hdr_s1.lat_digits;
		nxt.hemispheres       = hdr_s1.hemispheres;
		nxt.message_code      = hdr_s1.message_code;
		nxt.symbol_code       = hdr_s1.symbol_code;
		nxt.symbol_table      = hdr_s1.symbol_table;
		nxt.messaging_capable = hdr_s1.messaging_capable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			st_s2 <= nxt;
		end
	end

	always_comb begin
		spd = st_s2.sp10 + {7'd0, st_s2.q};
		if (st_s2.rev1 && spd >= SPEED_WRAP) begin
			spd = spd - SPEED_WRAP;
		end
		r100 = {1'b0, st_s2.r, 6'd0} + {2'b00, st_s2.r, 5'd0} + {5'd0, st_s2.r, 2'b00};
		cse  = r100 + {4'd0, st_s2.se};
		if (st_s2.rev1 && cse >= COURSE_WRAP) begin
			cse = cse - COURSE_WRAP;
		end

		res = '0;
		if (st_s2.ok && cse <= COURSE_MAX && spd <= SPEED_MAX) begin
			res.accepted          = 1'b1;
			res.lat_digits        = st_s2.lat_digits;
			res.hemispheres       = st_s2.hemispheres;
			res.lon_degrees       = st_s2.lon_dd;
			res.lon_minutes       = st_s2.lon_mm;
			res.lon_hundredths    = st_s2.lon_hh;
			res.speed             = spd[9:0];
			res.course            = cse[8:0];
			res.symbol_code       = st_s2.symbol_code;
			res.symbol_table      = st_s2.symbol_table;
			res.message_code      = st_s2.message_code;
			res.messaging_capable = st_s2.messaging_capable;
		end
	end

endmodule

// ===== rtl/micepd_checker.sv =====
// ----------------------------------------------------------------------------
// micepd_checker
// Port-level checks of the Mic-E decoder, bound to the top level.
// ----------------------------------------------------------------------------
module micepd_checker
	import micepd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input mic_out_t result
);

	// Every accepted word gives exactly one result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##3 !done)
		else $error("result without an accepted word");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted) |-> (result == '0))
		else $error("rejected word has nonzero fields");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.accepted) |-> (result.course <= 9'd360 &&
			result.speed <= 10'd999 && result.lon_degrees <= 8'd179 &&
			result.lon_minutes <= 7'd99 && result.message_code != 4'd8))
		else $error("accepted word has a field out of range");

endmodule

bind mic_e_position_decoder micepd_checker u_micepd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mic-E position decoder. A short table of
// headers covers the field extremes and each rejection rule, followed by
// random headers that are mostly well formed. Every decoded word is checked
// field by field against a table or a decoder model, in acceptance order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import micepd_pkg::*;

	localparam int RANDOM_HEADERS = 2000;
	localparam int DRAIN_CYCLES   = 10;

	localparam logic [63:0] GOOD_INFO = 64'h60642b441e504e3e;

	localparam mic_out_t REJECTED = '0;
	localparam mic_out_t GOOD_DECODE = '{
		accepted: 1'b1,
		lat_digits: 24'h352050,
		hemispheres: 2'd0,
		lon_degrees: 8'd72,
		lon_minutes: 7'd15,
		lon_hundredths: 7'd40,
		speed: 10'd25,
		course: 9'd250,
		symbol_code: 8'h3e,
		symbol_table: 8'h2f,
		message_code: 4'd0,
		messaging_capable: 1'b1
	};

	typedef struct {
		mic_in_t  hdr;
		bit       fixed;
		mic_out_t decoded;
	} header_case_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	mic_in_t  cmd;
	logic     done;
	mic_out_t result;

	mic_out_t     expected_decodes[$];
	header_case_t directed_headers[$];
	int           errors = 0;

	mic_e_position_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always #1 clk = ~clk;

	function automatic int unsigned char_value(input logic [7:0] c);
		return 32'(c) - 32'd28;
	endfunction

	function automatic logic [3:0] dest_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h4a) return 4'(c - 8'h41);
		if (c >= 8'h50 && c <= 8'h59) return 4'(c - 8'h50);
		return DIGIT_BLANK;
	endfunction

	function automatic logic table_char_ok(input logic [7:0] s);
		return s == CH_SLASH || s == CH_BSLASH || s == CH_STAR || s == CH_BANG ||
			(s >= 8'h30 && s <= 8'h39) || (s >= 8'h61 && s <= 8'h6a) ||
			(s >= 8'h41 && s <= 8'h5a);
	endfunction

	function automatic mic_out_t decode_mic_e(input mic_in_t h);
		mic_out_t    r;
		logic [7:0]  d [6];
		logic [7:0]  b [10];
		logic [3:0]  lat [6];
		logic        rev1;
		logic [3:0]  msg;
		logic [7:0]  tbl;
		int unsigned lon_dd, lon_mm, spd, cse, dc;
		int          i;
		r = '0;
		for (i = 0; i < 6; i++) d[i] = h.dest_chars[47 - 8 * i -: 8];
		for (i = 0; i < 8; i++) b[i] = h.info_head[63 - 8 * i -: 8];
		b[8] = h.info_byte_eight;
		b[9] = h.info_byte_nine;
		if (h.info_length > 9'd255 || h.dest_length != DEST_LEN) return r;
		for (i = 0; i < 6; i++) begin
			if (d[i] < 8'h30 || d[i] > 8'h5a || (d[i] > 8'h39 && d[i] < 8'h41)) return r;
			if (d[i] >= 8'h4d && d[i] <= 8'h4f) return r;
			if (i >= 3 && d[i] >= 8'h41 && d[i] <= 8'h4b) return r;
		end
		for (i = 1; i < 7; i++) begin
			if (b[i] < INFO_MIN || b[i] > INFO_MAX) return r;
		end
		if (b[0] == TYPE_CUR || b[0] == TYPE_OLD) begin
			rev1 = 1'b1;
		end else if (b[0] == TYPE_BETA_A || b[0] == TYPE_BETA_B) begin
			rev1 = 1'b0;
		end else begin
			return r;
		end
		if (h.info_length < (rev1 ? 9'd9 : 9'd8)) return r;

		// Any P..Z in the first three characters makes the code standard.
		msg = {1'b0, d[0] >= 8'h50, d[1] >= 8'h50, d[2] >= 8'h50};
		if (msg == 4'd0) begin
			if (d[0] >= 8'h41 && d[0] <= 8'h4b) msg |= 4'hc;
			if (d[1] >= 8'h41 && d[1] <= 8'h4b) msg |= 4'ha;
			if (d[2] >= 8'h41 && d[2] <= 8'h4b) msg |= 4'h9;
		end

		for (i = 0; i < 6; i++) lat[i] = dest_digit(d[i]);
		if (lat[0] == 4'd9) begin
			for (i = 1; i < 6; i++) begin
				if (lat[i] != 4'd0) return r;
			end
		end
		if (lat[2] != DIGIT_BLANK && lat[2] > 4'd5) return r;
		if (lat[4] != DIGIT_BLANK && lat[4] > 4'd5) return r;
		if (lat[0] == DIGIT_BLANK || lat[1] == DIGIT_BLANK) return r;

		lon_dd = char_value(b[1]);
		lon_mm = char_value(b[2]);
		if (rev1) begin
			if (d[4] >= 8'h50) lon_dd += 100;
			if (lon_dd >= 180 && lon_dd <= 189) lon_dd -= 80;
			if (lon_dd >= 190 && lon_dd <= 199) lon_dd -= 190;
			if (lon_mm >= 60) lon_mm -= 60;
		end
		dc = char_value(b[5]);
		spd = char_value(b[4]) * 10 + dc / 10;
		cse = (dc % 10) * 100 + char_value(b[6]);
		if (rev1) begin
			if (spd >= 800) spd -= 800;
			if (cse >= 400) cse -= 400;
		end
		if (cse > 360 || spd > 999) return r;

		tbl = rev1 ? b[8] : CH_SLASH;
		if (b[7] < SYM_MIN || b[7] > SYM_MAX || !table_char_ok(tbl)) return r;

		r.accepted = 1'b1;
		r.lat_digits = {lat[0], lat[1], lat[2], lat[3], lat[4], lat[5]};
		r.hemispheres = {d[5] >= 8'h50, d[3] >= 8'h50};
		r.lon_degrees = 8'(lon_dd);
		r.lon_minutes = 7'(lon_mm);
		r.lon_hundredths = 7'(char_value(b[3]));
		r.speed = 10'(spd);
		r.course = 9'(cse);
		r.symbol_code = b[7];
		r.symbol_table = tbl;
		r.message_code = msg;
		r.messaging_capable = h.info_length >= 9'd10 &&
			(b[9] == CH_RBRACKET || b[9] == CH_GT);
		return r;
	endfunction

	function automatic mic_in_t make_header(input logic [47:0] dest, input logic [3:0] dlen,
			input logic [63:0] info, input logic [7:0] b8, input logic [7:0] b9,
			input logic [8:0] len);
		mic_in_t h;
		h.dest_chars = dest;
		h.dest_length = dlen;
		h.info_head = info;
		h.info_byte_eight = b8;
		h.info_byte_nine = b9;
		h.info_length = len;
		return h;
	endfunction

	function automatic void add_case(input mic_in_t h, input bit fixed, input mic_out_t r);
		header_case_t c;
		c.hdr = h;
		c.fixed = fixed;
		c.decoded = r;
		directed_headers.push_back(c);
	endfunction

	function automatic logic [7:0] random_dest_char(input int pos, input bit lat_nine);
		int unsigned v;
		if (!lat_nine && $urandom_range(0, 19) == 0) begin
			if ($urandom_range(0, 1) == 0) return 8'h5a;
			return (pos < 3 && $urandom_range(0, 1) == 0) ? 8'h4b : 8'h4c;
		end
		if (lat_nine) v = (pos == 0) ? 9 : 0;
		else if ((pos == 2 || pos == 4) && $urandom_range(0, 9) != 0) v = $urandom_range(0, 5);
		else v = $urandom_range(0, 9);
		case ($urandom_range(0, pos < 3 ? 2 : 1))
			0: return 8'(32'h30 + v);
			1: return 8'(32'h50 + v);
			default: return 8'(32'h41 + v);
		endcase
	endfunction

	function automatic logic [7:0] random_table_char();
		case ($urandom_range(0, 7))
			0: return CH_SLASH;
			1: return CH_BSLASH;
			2: return CH_STAR;
			3: return CH_BANG;
			4: return 8'($urandom_range(32'h30, 32'h39));
			5: return 8'($urandom_range(32'h61, 32'h6a));
			6: return 8'($urandom_range(32'h41, 32'h5a));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic mic_in_t random_header();
		mic_in_t      h;
		int unsigned  mode;
		int           i;
		bit           lat_nine;
		logic [7:0]   type_byte;
		mode = $urandom_range(0, 19);
		if (mode < 2) begin
			h.dest_chars = 48'({$urandom, $urandom});
			h.dest_length = 4'($urandom);
			h.info_head = {$urandom, $urandom};
			h.info_byte_eight = 8'($urandom);
			h.info_byte_nine = 8'($urandom);
			h.info_length = 9'($urandom);
			return h;
		end
		lat_nine = $urandom_range(0, 19) == 0;
		for (i = 0; i < 6; i++) h.dest_chars[47 - 8 * i -: 8] = random_dest_char(i, lat_nine);
		h.dest_length = ($urandom_range(0, 19) == 0) ? 4'($urandom) : DEST_LEN;
		case ($urandom_range(0, 3))
			0: type_byte = TYPE_CUR;
			1: type_byte = TYPE_OLD;
			2: type_byte = TYPE_BETA_A;
			default: type_byte = TYPE_BETA_B;
		endcase
		h.info_head[63:56] = type_byte;
		for (i = 1; i < 7; i++) h.info_head[63 - 8 * i -: 8] = 8'($urandom_range(32'h1c, 32'h7f));
		h.info_head[7:0] = ($urandom_range(0, 15) == 0) ? 8'($urandom) :
			8'($urandom_range(32'h20, 32'h7e));
		h.info_byte_eight = random_table_char();
		case ($urandom_range(0, 2))
			0: h.info_byte_nine = CH_RBRACKET;
			1: h.info_byte_nine = CH_GT;
			default: h.info_byte_nine = 8'($urandom);
		endcase
		h.info_length = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(7, 16));
		if (mode < 5) begin
			if ($urandom_range(0, 1) == 0) begin
				i = $urandom_range(0, 5);
				h.dest_chars[47 - 8 * i -: 8] = 8'($urandom);
			end else begin
				i = $urandom_range(0, 7);
				h.info_head[63 - 8 * i -: 8] = 8'($urandom);
			end
		end
		return h;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		mic_out_t want;
		if (arst_n && done) begin
			if (expected_decodes.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none actual 0x%0h", $time, result);
			end else begin
				want = expected_decodes.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(result.accepted));
				check_field("lat_digits", 32'(want.lat_digits), 32'(result.lat_digits));
				check_field("hemispheres", 32'(want.hemispheres), 32'(result.hemispheres));
				check_field("lon_degrees", 32'(want.lon_degrees), 32'(result.lon_degrees));
				check_field("lon_minutes", 32'(want.lon_minutes), 32'(result.lon_minutes));
				check_field("lon_hundredths", 32'(want.lon_hundredths),
					32'(result.lon_hundredths));
				check_field("speed", 32'(want.speed), 32'(result.speed));
				check_field("course", 32'(want.course), 32'(result.course));
				check_field("symbol_code", 32'(want.symbol_code), 32'(result.symbol_code));
				check_field("symbol_table", 32'(want.symbol_table), 32'(result.symbol_table));
				check_field("message_code", 32'(want.message_code), 32'(result.message_code));
				check_field("messaging_capable", 32'(want.messaging_capable),
					32'(result.messaging_capable));
			end
		end
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		header_case_t c;
		int           total, idx, burst_left, gap;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;

		add_case(make_header("352050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, GOOD_DECODE);
		add_case(make_header('0, 4'd0, '0, 8'd0, 8'd0, 9'd0), 1, REJECTED);
		add_case(make_header('1, 4'd15, '1, 8'hff, 8'hff, 9'd511), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd256),
			1, REJECTED);
		add_case(make_header("352050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_GT, 9'd255),
			0, REJECTED);
		add_case(make_header("352050", 4'd5, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("3:2050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("352A50", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("M52050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h601b2b441e504e3e, CH_SLASH,
			CH_RBRACKET, 9'd10), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h60642b441e50803e, CH_SLASH,
			CH_RBRACKET, 9'd10), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h00642b441e504e3e, CH_SLASH,
			CH_RBRACKET, 9'd10), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd8),
			1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h1c642b441e504e3e, CH_SLASH,
			CH_RBRACKET, 9'd7), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h1d642b441e504e3e, 8'h00,
			CH_RBRACKET, 9'd8), 0, REJECTED);
		add_case(make_header("952050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("900000", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			0, REJECTED);
		add_case(make_header("356050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("3520L0", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			0, REJECTED);
		add_case(make_header("L52050", DEST_LEN, GOOD_INFO, CH_SLASH, CH_RBRACKET, 9'd10),
			1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h1c642b441e51593e, CH_SLASH,
			CH_RBRACKET, 9'd9), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h1c642b441e51583e, CH_SLASH,
			CH_RBRACKET, 9'd9), 0, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h1d642b447f761c7e, CH_SLASH,
			CH_GT, 9'd12), 0, REJECTED);
		add_case(make_header("3520P0", DEST_LEN, 64'h60716244717a303e, CH_SLASH,
			CH_GT, 9'd12), 0, REJECTED);
		add_case(make_header("P3A0PZ", DEST_LEN, 64'h277b2b441e504e3e, 8'h6a,
			CH_RBRACKET, 9'd9), 0, REJECTED);
		add_case(make_header("ABC050", DEST_LEN, 64'h60642b441e504e7e, CH_BSLASH,
			CH_GT, 9'd10), 0, REJECTED);
		add_case(make_header("352050", DEST_LEN, 64'h60642b441e504e1f, CH_SLASH,
			CH_RBRACKET, 9'd10), 1, REJECTED);
		add_case(make_header("352050", DEST_LEN, GOOD_INFO, 8'h23, CH_RBRACKET, 9'd10),
			1, REJECTED);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = directed_headers.size() + RANDOM_HEADERS;
		burst_left = $urandom_range(1, 12);
		for (idx = 0; idx < total; idx++) begin
			if (idx < directed_headers.size()) begin
				c = directed_headers[idx];
			end else begin
				c.hdr = random_header();
				c.fixed = 0;
			end
			cmd <= c.hdr;
			start <= 1'b1;
			@(posedge clk);
			while (busy) @(posedge clk);
			expected_decodes.push_back(c.fixed ? c.decoded : decode_mic_e(c.hdr));
			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
					$urandom_range(1, 12);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		start <= 1'b0;

		while (expected_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
